### rtl/frame_diff_dirty_rect_core_assert.svh
// Assertion macros used by the frame difference detector back end.
`ifndef FRAME_DIFF_DIRTY_RECT_CORE_ASSERT_SVH
`define FRAME_DIFF_DIRTY_RECT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FDR_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fdr_pkg.sv
// Shared types, constants and pixel conversion for the frame difference detector.
package fdr_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 10;
	localparam int DIM_W       = 11;
	localparam int HALF_W      = DIM_W - 1;
	localparam int IDX_W       = 19;
	localparam int STORE_DEPTH = (MAX_WIDTH / 2) * MAX_HEIGHT;
	localparam int SHIFT_W     = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [31:0] CHECKER_A  = 32'h18e3_20e4;
	localparam logic [31:0] CHECKER_B  = 32'h20e4_18e3;
	localparam logic [31:0] FLAT_WORD  = 32'h18e3_18e3;
	localparam logic [31:0] FIELD_MASK = 32'h001f_001f;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_RED_SHIFT    = 3'd2,
		REG_GREEN_SHIFT  = 3'd3,
		REG_BLUE_SHIFT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0]      word;
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] red;
		logic [SHIFT_W-1:0] green;
		logic [SHIFT_W-1:0] blue;
	} shifts_t;

	function automatic logic [31:0] to_remote(input logic [31:0] p, input shifts_t sh);
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		r = (p >> sh.red) & FIELD_MASK;
		g = (p >> sh.green) & FIELD_MASK;
		b = (p >> sh.blue) & FIELD_MASK;
		return r | (g << 5) | (b << 10);
	endfunction

endpackage

### rtl/frame_diff_dirty_rect_core.sv
// Throughput: one word per cycle while result_ready is high and the store is not clearing;
// the compare store takes one read and one write each cycle.
// The front end stalls when the four-entry queue is full or the store is being cleared.
// Reset: all control clears; the compare store's 524288 entries are zeroed by a pass
// during which live_ready stays low and configuration writes are still taken.
module frame_diff_dirty_rect_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fdr_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          live_valid,
	output logic                          live_ready,
	input  logic [31:0]                   live_word,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          changed,
	output logic [31:0]                   remote_word,
	output logic [18:0]                   word_index,
	output logic                          frame_end,
	output logic                          any_dirty,
	output logic [9:0]                    rect_left,
	output logic [9:0]                    rect_top,
	output logic [10:0]                   rect_right,
	output logic [10:0]                   rect_bottom
);
	import fdr_pkg::*;

	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	shifts_t          shifts_q;

	logic             space;
	logic             push;
	item_t            push_item;
	logic             has_room;
	q_head_t          head;
	logic             pop;
	logic             clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(1024);
			frame_height_q <= DIM_W'(1024);
			shifts_q.red   <= SHIFT_W'(11);
			shifts_q.green <= SHIFT_W'(6);
			shifts_q.blue  <= SHIFT_W'(0);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_RED_SHIFT:    shifts_q.red   <= cfg_data[SHIFT_W-1:0];
				REG_GREEN_SHIFT:  shifts_q.green <= cfg_data[SHIFT_W-1:0];
				REG_BLUE_SHIFT:   shifts_q.blue  <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	assign space = has_room && !clearing;

	fdr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.live_valid   (live_valid),
		.live_ready   (live_ready),
		.live_word    (live_word),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.space        (space),
		.push         (push),
		.push_item    (push_item)
	);

	fdr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.has_room  (has_room),
		.head      (head),
		.pop       (pop)
	);

	fdr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.shifts       (shifts_q),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.changed      (changed),
		.remote_word  (remote_word),
		.word_index   (word_index),
		.frame_end    (frame_end),
		.any_dirty    (any_dirty),
		.rect_left    (rect_left),
		.rect_top     (rect_top),
		.rect_right   (rect_right),
		.rect_bottom  (rect_bottom)
	);

endmodule

### rtl/fdr_front.sv
// Front end: accepts framebuffer words, tracks raster position and word index.
module fdr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       live_valid,
	output logic                       live_ready,
	input  logic [31:0]                live_word,
	input  logic [fdr_pkg::DIM_W-1:0]  frame_width,
	input  logic [fdr_pkg::DIM_W-1:0]  frame_height,
	input  logic                       space,
	output logic                       push,
	output fdr_pkg::item_t             push_item
);
	import fdr_pkg::*;

	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [DIM_W-1:0]        w_even;
	logic [DIM_W-1:0]        eff_w;
	logic [DIM_W-1:0]        eff_h;
	logic [HALF_W-1:0]       half_w;
	logic [ROW_W+HALF_W-1:0] row_base;
	logic                    line_end;
	logic                    frame_end;

	always_comb begin
		w_even = {frame_width[DIM_W-1:1], 1'b0};
		if (w_even < DIM_W'(2)) begin
			eff_w = DIM_W'(2);
		end else if (w_even > DIM_W'(MAX_WIDTH)) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end else begin
			eff_w = w_even;
		end
		if (frame_height < DIM_W'(1)) begin
			eff_h = DIM_W'(1);
		end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = frame_height;
		end
		half_w    = eff_w[DIM_W-1:1];
		row_base  = (ROW_W+HALF_W)'(row_q) * (ROW_W+HALF_W)'(half_w);
		line_end  = ({1'b0, col_q} + DIM_W'(2)) >= eff_w;
		frame_end = line_end && (({1'b0, row_q} + DIM_W'(1)) >= eff_h);
	end

	assign live_ready = space;
	assign push       = live_valid && space;

	always_comb begin
		push_item.word      = live_word;
		push_item.idx       = row_base[IDX_W-1:0] + IDX_W'(col_q[COL_W-1:1]);
		push_item.col       = col_q;
		push_item.row       = row_q;
		push_item.frame_end = frame_end;
	end

	// advance the raster position on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (line_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(2);
			end
		end
	end

endmodule

### rtl/fdr_queue.sv
// Short FIFO between the front end and the compare back end.
module fdr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fdr_pkg::item_t    push_item,
	output logic              has_room,
	output fdr_pkg::q_head_t  head,
	input  logic              pop
);
	import fdr_pkg::*;

	item_t             entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign has_room   = count_q != QCNT_W'(QDEPTH);
	assign head.valid = count_q != '0;
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

### rtl/fdr_back.sv
// Back end: compare store, change detection, bounding box and output register.
`include "frame_diff_dirty_rect_core_assert.svh"
module fdr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fdr_pkg::q_head_t          head,
	output logic                      pop,
	input  fdr_pkg::shifts_t          shifts,
	output logic                      clearing,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic                      changed,
	output logic [31:0]               remote_word,
	output logic [fdr_pkg::IDX_W-1:0] word_index,
	output logic                      frame_end,
	output logic                      any_dirty,
	output logic [9:0]                rect_left,
	output logic [9:0]                rect_top,
	output logic [10:0]               rect_right,
	output logic [10:0]               rect_bottom
);
	import fdr_pkg::*;

	logic [31:0]      store_q [STORE_DEPTH];
	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic             valid_s1;
	item_t            item_s1;
	logic [31:0]      rd_s1;
	logic             hit_s1;
	logic [31:0]      fwd_s1;

	logic             seen_q;
	logic [COL_W-1:0] min_x_q;
	logic [COL_W-1:0] max_x_q;
	logic [ROW_W-1:0] min_y_q;
	logic [ROW_W-1:0] max_y_q;

	logic             res_valid_q;
	logic             res_changed_q;
	logic [31:0]      res_remote_q;
	logic [IDX_W-1:0] res_index_q;
	logic             res_frame_end_q;
	logic             res_any_dirty_q;
	logic [9:0]       res_left_q;
	logic [9:0]       res_top_q;
	logic [10:0]      res_right_q;
	logic [10:0]      res_bottom_q;

	logic             adv2;
	logic             adv1;
	logic             load1;
	logic [31:0]      stored;
	logic             chg;
	logic [31:0]      pix;
	logic [31:0]      remote;
	logic             seen_n;
	logic [COL_W-1:0] nmin_x;
	logic [COL_W-1:0] nmax_x;
	logic [ROW_W-1:0] nmin_y;
	logic [ROW_W-1:0] nmax_y;
	logic             report;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;

	assign adv2     = !res_valid_q || result_ready;
	assign adv1     = valid_s1 && adv2;
	assign load1    = head.valid && (!valid_s1 || adv1) && !clearing_q;
	assign pop      = load1;
	assign clearing = clearing_q;

	always_comb begin
		// the previous word wrote this entry on the edge that read it
		stored = hit_s1 ? fwd_s1 : rd_s1;
		chg    = stored != item_s1.word;
		if (item_s1.word == CHECKER_A || item_s1.word == CHECKER_B) begin
			pix = FLAT_WORD;
		end else begin
			pix = item_s1.word;
		end
		remote = to_remote(pix, shifts);

		seen_n = seen_q;
		nmin_x = min_x_q;
		nmax_x = max_x_q;
		nmin_y = min_y_q;
		nmax_y = max_y_q;
		if (chg) begin
			seen_n = 1'b1;
			if (!seen_q) begin
				nmin_x = item_s1.col;
				nmax_x = item_s1.col;
				nmin_y = item_s1.row;
				nmax_y = item_s1.row;
			end else begin
				if (item_s1.col < min_x_q) nmin_x = item_s1.col;
				if (item_s1.col > max_x_q) nmax_x = item_s1.col;
				if (item_s1.row < min_y_q) nmin_y = item_s1.row;
				if (item_s1.row > max_y_q) nmax_y = item_s1.row;
			end
		end
		report = item_s1.frame_end && seen_n;

		wr_en   = clearing_q || (adv1 && chg);
		wr_addr = clearing_q ? clr_addr_q : item_s1.idx;
		wr_data = clearing_q ? '0 : item_s1.word;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (load1) begin
			rd_s1 <= store_q[head.item.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == IDX_W'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			item_s1 <= head.item;
			hit_s1  <= adv1 && (item_s1.idx == head.item.idx);
			fwd_s1  <= item_s1.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load1) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	// drop the box after the frame report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
		end else if (adv1) begin
			if (item_s1.frame_end) begin
				seen_q  <= 1'b0;
				min_x_q <= '0;
				max_x_q <= '0;
				min_y_q <= '0;
				max_y_q <= '0;
			end else begin
				seen_q  <= seen_n;
				min_x_q <= nmin_x;
				max_x_q <= nmax_x;
				min_y_q <= nmin_y;
				max_y_q <= nmax_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			res_changed_q   <= chg;
			res_remote_q    <= chg ? remote : '0;
			res_index_q     <= item_s1.idx;
			res_frame_end_q <= item_s1.frame_end;
			res_any_dirty_q <= report;
			res_left_q      <= report ? nmin_x : '0;
			res_top_q       <= report ? nmin_y : '0;
			res_right_q     <= report ? ({1'b0, nmax_x} + 11'd2) : '0;
			res_bottom_q    <= report ? ({1'b0, nmax_y} + 11'd1) : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign changed      = res_changed_q;
	assign remote_word  = res_remote_q;
	assign word_index   = res_index_q;
	assign frame_end    = res_frame_end_q;
	assign any_dirty    = res_any_dirty_q;
	assign rect_left    = res_left_q;
	assign rect_top     = res_top_q;
	assign rect_right   = res_right_q;
	assign rect_bottom  = res_bottom_q;

	`FDR_ASSERT(a_no_load_in_clear, clearing_q, !load1 && !valid_s1, "word taken during store clear")
	`FDR_ASSERT(a_dirty_at_end, res_valid_q && res_any_dirty_q, res_frame_end_q, "dirty flag off frame end")
	`FDR_ASSERT(a_quiet_remote, res_valid_q && !res_changed_q, res_remote_q == '0, "remote word on unchanged beat")
	`FDR_ASSERT_NEXT(a_box_seen, adv1 && chg && !item_s1.frame_end, seen_q, "change not recorded in box")

endmodule
